// ===== src/ntc_thermistor_temperature_defines.svh =====
// assertion macros for the ntc thermistor temperature block
// no dependencies
`ifndef NTC_THERMISTOR_TEMPERATURE_DEFINES_SVH
`define NTC_THERMISTOR_TEMPERATURE_DEFINES_SVH
// implication checked on every clock unless in reset
`define NTC_ASSERT_IMP(label, clk_i, rst_ni, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define NTC_ASSERT_NXT(label, clk_i, rst_ni, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== src/ntc_pkg.sv =====
// shared constants and the resistance table function for the ntc thermistor block
// no dependencies
`default_nettype none
package ntc_pkg;
  localparam int unsigned AdcBits = 12;
  localparam int unsigned TableEntries = 25;
  localparam int unsigned TempStepX10 = 50;
  localparam logic signed [10:0] TempMinX10 = -11'sd200;
  localparam logic signed [10:0] TempMaxX10 = 11'sd1000;
  localparam logic [23:0] ROpen = 24'd200000;
  localparam logic [23:0] RShort = 24'd100;
  localparam logic [23:0] VSat = 24'hFFFFFF;
  localparam logic [12:0] SupplyBaseMv = 13'd2400;
  localparam logic [1:0] REG_SAMPLE_COUNT = 2'd0;
  localparam logic [1:0] REG_REF_MV = 2'd1;
  localparam logic [1:0] REG_PULLUP = 2'd2;

  function automatic logic [16:0] rt_rom(input logic [4:0] k);
    logic [16:0] v;
    unique case (k)
      5'd0: v = 17'd97100;  5'd1: v = 17'd72700;  5'd2: v = 17'd54800;
      5'd3: v = 17'd41800;  5'd4: v = 17'd32600;  5'd5: v = 17'd25600;
      5'd6: v = 17'd19900;  5'd7: v = 17'd15800;  5'd8: v = 17'd12500;
      5'd9: v = 17'd10000;  5'd10: v = 17'd8100;  5'd11: v = 17'd6500;
      5'd12: v = 17'd5300;  5'd13: v = 17'd4350;  5'd14: v = 17'd3600;
      5'd15: v = 17'd3000;  5'd16: v = 17'd2500;  5'd17: v = 17'd2100;
      5'd18: v = 17'd1800;  5'd19: v = 17'd1520;  5'd20: v = 17'd1300;
      5'd21: v = 17'd1110;  5'd22: v = 17'd960;   5'd23: v = 17'd830;
      5'd24: v = 17'd720;
      default: v = 17'd720;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

// ===== src/ntc_if.sv =====
// valid/ready channel interfaces for the ntc thermistor block
// depends on ntc_pkg for the adc sample width
`default_nettype none
interface ntc_in_if
  import ntc_pkg::*;
();
  logic valid;
  logic ready;
  logic [AdcBits-1:0] ntc_sample;
  logic [AdcBits-1:0] ref_sample;
  logic [3:0] supply_code;
  modport source(output valid, ntc_sample, ref_sample, supply_code, input ready);
  modport sink(input valid, ntc_sample, ref_sample, supply_code, output ready);
endinterface

interface ntc_out_if ();
  logic valid;
  logic ready;
  logic signed [10:0] temperature_x10;
  logic [15:0] voltage_mv;
  logic [23:0] resistance_ohm;
  modport source(output valid, temperature_x10, voltage_mv, resistance_ohm, input ready);
  modport sink(input valid, temperature_x10, voltage_mv, resistance_ohm, output ready);
endinterface
`default_nettype wire

// ===== src/ntc_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
// depends on ntc_pkg
`default_nettype none
module ntc_div
  import ntc_pkg::*;
#(
  parameter int NumW = 48,
  parameter int DenW = 24
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [NumW-1:0] num,
  input  wire logic [DenW-1:0] den,
  output logic                 done,
  output logic [NumW-1:0]      quo
);
  localparam int CntW = $clog2(NumW + 1);
  logic [NumW-1:0] q_r;
  logic [DenW:0]   rem_r;
  logic [DenW-1:0] den_r;
  logic [CntW-1:0] cnt_r;
  logic            busy_r;
  logic [DenW:0]   trial;
  logic [DenW:0]   diff;

  assign trial = {rem_r[DenW-1:0], q_r[NumW-1]};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        q_r    <= num;
        rem_r  <= '0;
        den_r  <= den;
        cnt_r  <= CntW'(NumW);
      end else if (busy_r) begin
        if (!diff[DenW]) begin
          rem_r <= diff;
          q_r   <= {q_r[NumW-2:0], 1'b1};
        end else begin
          rem_r <= trial;
          q_r   <= {q_r[NumW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
  assign quo = q_r;
endmodule
`default_nettype wire

// ===== src/ntc_thermistor_temperature.sv =====
// ntc thermistor temperature top level: accumulation, sequencer, result register
// depends on ntc_pkg, ntc_if.sv, ntc_div and the assertion macro header
// usage:
//   in channel: one request per pair of adc samples (ntc, ref) plus supply code
//   out channel: one request per finished measurement (temperature, mv, ohm)
//   cfg port: apb-style writes, sample_count @0, ref_voltage_mv @4, pullup_ohm @8
// processing:
//   a pair that does not finish a measurement is always accepted, also while busy
//   the finishing pair starts up to five divisions on one shared bit-serial
//   divider (two averages, voltage, resistance, interpolation fraction); each
//   is started, runs the divider loop and hands its quotient back; a table
//   walk of up to 24 segments precedes the fraction, then the output register
// reset:
//   accumulators and pair count cleared, registers back to 8 / 1200 / 10000
// stall:
//   the result sits in the output register until taken; the next pairs are
//   still accepted and summed meanwhile, only a new finishing pair waits
`default_nettype none
`include "ntc_thermistor_temperature_defines.svh"
module ntc_thermistor_temperature
  import ntc_pkg::*;
#(
  parameter int MAX_SAMPLES = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ntc_in_if.sink     in_ch,
  ntc_out_if.source  out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam int AccW = AdcBits + $clog2(MAX_SAMPLES + 1);
  localparam int NumW = 48;
  localparam int DenW = 24;

  typedef enum logic [3:0] {
    S_IDLE, S_AVG_N, S_WAIT_N, S_AVG_R, S_WAIT_R, S_VOLT, S_WAIT_V,
    S_RES, S_WAIT_RES, S_SCAN, S_FRAC, S_WAIT_F, S_OUT
  } state_t;

  // configuration registers
  logic [6:0]  sample_count_r;
  logic [11:0] ref_mv_r;
  logic [19:0] pullup_r;
  logic        cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= 7'd8;
      ref_mv_r       <= 12'd1200;
      pullup_r       <= 20'd10000;
    end else if (cfg_wr) begin
      priority case (cfg_paddr[3:2])
        REG_SAMPLE_COUNT: sample_count_r <= cfg_pwdata[6:0];
        REG_REF_MV:       ref_mv_r <= cfg_pwdata[11:0];
        REG_PULLUP:       pullup_r <= cfg_pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_SAMPLE_COUNT: cfg_prdata = {25'd0, sample_count_r};
      REG_REF_MV:       cfg_prdata = {20'd0, ref_mv_r};
      REG_PULLUP:       cfg_prdata = {12'd0, pullup_r};
      default:          cfg_prdata = '0;
    endcase
  end

  // effective count, clamped to 1..MAX_SAMPLES
  logic [8:0] eff_count;
  always_comb begin
    if (sample_count_r == 7'd0) eff_count = 9'd1;
    else if (32'(sample_count_r) > MAX_SAMPLES) eff_count = 9'(MAX_SAMPLES);
    else eff_count = {2'b00, sample_count_r};
  end

  // accumulation
  logic [AccW-1:0] ntc_acc_r, ref_acc_r, ntc_sum_r, ref_sum_r;
  logic [8:0]      pairs_r;
  logic [3:0]      supply_code_r;
  state_t          state_r;
  logic            last_pair;
  logic            in_fire;
  logic            busy;
  assign busy      = (state_r != S_IDLE);
  assign last_pair = (pairs_r + 9'd1) >= eff_count;
  assign in_ch.ready = !(last_pair && busy);
  assign in_fire = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ntc_acc_r <= '0;
      ref_acc_r <= '0;
      pairs_r   <= '0;
    end else if (in_fire) begin
      if (last_pair) begin
        ntc_acc_r <= '0;
        ref_acc_r <= '0;
        pairs_r   <= '0;
      end else begin
        ntc_acc_r <= ntc_acc_r + AccW'(in_ch.ntc_sample);
        ref_acc_r <= ref_acc_r + AccW'(in_ch.ref_sample);
        pairs_r   <= pairs_r + 9'd1;
      end
    end
  end

  // shared divider
  logic            div_start, div_done;
  logic [NumW-1:0] div_num, div_quo;
  logic [DenW-1:0] div_den;
  ntc_div #(.NumW(NumW), .DenW(DenW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  // sequencer datapath
  logic [23:0]       ntc_avg_r, ref_avg_r, volt_r, res_r;
  logic [13:0]       vdd_mv;
  logic [4:0]        k_r;
  logic signed [10:0] temp_r;
  logic              ovalid_r;
  logic signed [10:0] otemp_r;
  logic [15:0]       ovolt_r;
  logic [23:0]       ores_r;
  logic [16:0]       rom_hi, rom_lo;
  logic              res_div;
  logic              out_load;

  assign vdd_mv = {1'b0, SupplyBaseMv} + 14'(supply_code_r) * 14'd100;
  assign rom_hi = rt_rom(k_r);
  assign rom_lo = rt_rom(k_r + 5'd1);
  // voltage between the near-ground and near-supply limits needs the divider
  assign res_div = (volt_r < 24'(vdd_mv) - 24'd10) && (volt_r >= 24'd10);
  // result register free or being emptied this cycle
  assign out_load = (state_r == S_OUT) && (!ovalid_r || out_ch.ready);

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state_r)
      S_AVG_N: begin
        div_start = 1'b1;
        div_num = NumW'(ntc_sum_r);
        div_den = DenW'(eff_count);
      end
      S_AVG_R: begin
        div_start = 1'b1;
        div_num = NumW'(ref_sum_r);
        div_den = DenW'(eff_count);
      end
      S_VOLT: begin
        div_start = (ref_avg_r != 24'd0);
        div_num = NumW'(ref_mv_r) * NumW'(ntc_avg_r);
        div_den = ref_avg_r;
      end
      S_RES: begin
        div_start = res_div;
        div_num = NumW'(pullup_r) * NumW'(volt_r);
        div_den = DenW'(vdd_mv) - volt_r;
      end
      S_FRAC: begin
        div_start = 1'b1;
        div_num = NumW'(TempStepX10) * NumW'(17'(rom_hi) - 17'(res_r));
        div_den = DenW'(rom_hi - rom_lo);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      if (out_load) ovalid_r <= 1'b1;
      else if (out_ch.ready) ovalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_fire && last_pair) begin
            ntc_sum_r     <= ntc_acc_r + AccW'(in_ch.ntc_sample);
            ref_sum_r     <= ref_acc_r + AccW'(in_ch.ref_sample);
            supply_code_r <= in_ch.supply_code;
            state_r       <= S_AVG_N;
          end
        end
        S_AVG_N: state_r <= S_WAIT_N;
        S_WAIT_N: if (div_done) begin
          ntc_avg_r <= div_quo[23:0];
          state_r <= S_AVG_R;
        end
        S_AVG_R: state_r <= S_WAIT_R;
        S_WAIT_R: if (div_done) begin
          ref_avg_r <= div_quo[23:0];
          state_r <= S_VOLT;
        end
        S_VOLT: begin
          if (ref_avg_r == 24'd0) begin
            volt_r <= VSat;
            state_r <= S_RES;
          end else begin
            state_r <= S_WAIT_V;
          end
        end
        S_WAIT_V: if (div_done) begin
          volt_r <= (div_quo > NumW'(VSat)) ? VSat : div_quo[23:0];
          state_r <= S_RES;
        end
        S_RES: begin
          k_r <= '0;
          if (volt_r >= 24'(vdd_mv) - 24'd10) begin
            res_r <= ROpen;
            state_r <= S_SCAN;
          end else if (volt_r < 24'd10) begin
            res_r <= RShort;
            state_r <= S_SCAN;
          end else begin
            state_r <= S_WAIT_RES;
          end
        end
        S_WAIT_RES: if (div_done) begin
          res_r <= (div_quo > NumW'(VSat)) ? VSat : div_quo[23:0];
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          // walk one table segment per cycle
          if (res_r <= 24'(rt_rom(5'(TableEntries - 1)))) begin
            temp_r <= TempMaxX10;
            state_r <= S_OUT;
          end else if (res_r >= 24'(rt_rom(5'd0))) begin
            temp_r <= TempMinX10;
            state_r <= S_OUT;
          end else if (res_r >= 24'(rom_lo)) begin
            state_r <= S_FRAC;
          end else begin
            k_r <= k_r + 5'd1;
          end
        end
        S_FRAC: state_r <= S_WAIT_F;
        S_WAIT_F: if (div_done) begin
          temp_r <= TempMinX10 + 11'(k_r) * 11'sd50 + 11'(div_quo[5:0]);
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            otemp_r  <= temp_r;
            ovolt_r  <= volt_r[15:0];
            ores_r   <= res_r;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.temperature_x10 = otemp_r;
  assign out_ch.voltage_mv = ovolt_r;
  assign out_ch.resistance_ohm = ores_r;

  `NTC_ASSERT_IMP(a_pairs_bound, clk, rst_n, 1'b1, pairs_r < 9'(MAX_SAMPLES), "pair count over max")
  `NTC_ASSERT_NXT(a_out_hold, clk, rst_n, ovalid_r && !out_ch.ready, ovalid_r && $stable(ores_r), "result lost")
  `NTC_ASSERT_IMP(a_no_start_idle, clk, rst_n, state_r == S_IDLE, !div_start, "divider started while idle")
endmodule
`default_nettype wire
